### rtl/ucdp_pkg.sv
package ucdp_pkg;

  // descriptor types
  localparam logic [7:0] DESC_CONFIG    = 8'h02;
  localparam logic [7:0] DESC_INTERFACE = 8'h04;
  localparam logic [7:0] DESC_ENDPOINT  = 8'h05;

  // interface class codes
  localparam logic [7:0] CLASS_STORAGE   = 8'h08;
  localparam logic [7:0] SUBCLASS_SCSI   = 8'h06;
  localparam logic [7:0] PROTO_BULK_ONLY = 8'h50;
  localparam logic [7:0] CLASS_HUB       = 8'h09;

  // endpoint transfer types and direction bit
  localparam logic [1:0] XFER_BULK = 2'b10;
  localparam logic [1:0] XFER_INT  = 2'b11;
  localparam int unsigned EP_DIR_BIT = 7;

  // minimum descriptor lengths
  localparam logic [7:0] MIN_DESC_LEN   = 8'd2;
  localparam logic [7:0] MIN_CONFIG_LEN = 8'd9;
  localparam logic [7:0] MIN_ITF_LEN    = 8'd9;
  localparam logic [7:0] MIN_EP_LEN     = 8'd7;

  localparam int unsigned NUM_FIELDS = 6;
  localparam int unsigned OUT_BITS   = 99;
  localparam int unsigned OUT_BYTES  = (OUT_BITS + 7) / 8;
  localparam int unsigned OUT_PAD    = OUT_BYTES * 8 - OUT_BITS;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic        is_msc;
    logic        is_hub;
    logic [7:0]  cfg_value;
    logic [7:0]  msc_interface;
    logic [7:0]  bulk_in_address;
    logic [15:0] bulk_in_max_packet;
    logic [7:0]  bulk_out_address;
    logic [15:0] bulk_out_max_packet;
    logic [7:0]  hub_int_address;
    logic [15:0] hub_int_max_packet;
    logic [7:0]  hub_poll_interval;
  } result_t;

endpackage

### rtl/ucdp_in_stage.sv
module ucdp_in_stage
  import ucdp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_data_i,
  input  logic       s_last_i,
  input  logic       advance_i,
  output logic       item_valid_o,
  output in_item_t   item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  // holding register frees up in the same cycle its byte moves on
  assign s_ready_o = !valid_q || advance_i;
  assign valid_d   = (s_valid_i && s_ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q.data <= s_data_i;
      item_q.last <= s_last_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### rtl/ucdp_parser.sv
module ucdp_parser
  import ucdp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  in_item_t item_i,
  output result_t  result_o
);

  logic [7:0]  idx_q, idx_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  field_q [NUM_FIELDS];
  logic [7:0]  field_d [NUM_FIELDS];
  logic        first_q, first_d;
  logic        failed_q, failed_d;
  logic        in_msc_q, in_msc_d;
  logic        in_hub_q, in_hub_d;
  logic        found_msc_q, found_msc_d;
  logic        found_hub_q, found_hub_d;
  logic [7:0]  config_q, config_d;
  logic [7:0]  msc_itf_q, msc_itf_d;
  logic [7:0]  bin_addr_q, bin_addr_d;
  logic [15:0] bin_mps_q, bin_mps_d;
  logic [7:0]  bout_addr_q, bout_addr_d;
  logic [15:0] bout_mps_q, bout_mps_d;
  logic [7:0]  hub_addr_q, hub_addr_d;
  logic [15:0] hub_mps_q, hub_mps_d;
  logic [7:0]  hub_ival_q, hub_ival_d;

  logic [7:0]  d;
  logic        fail_now;
  logic        done;
  logic        msc_match;
  logic        hub_match;
  logic [15:0] ep_mps;

  always_comb begin
    d        = item_i.data;
    idx_d    = idx_q;
    len_d    = len_q;
    type_d   = type_q;
    field_d  = field_q;
    first_d  = first_q;
    failed_d = failed_q;
    in_msc_d = in_msc_q;
    in_hub_d = in_hub_q;
    found_msc_d = found_msc_q;
    found_hub_d = found_hub_q;
    config_d    = config_q;
    msc_itf_d   = msc_itf_q;
    bin_addr_d  = bin_addr_q;
    bin_mps_d   = bin_mps_q;
    bout_addr_d = bout_addr_q;
    bout_mps_d  = bout_mps_q;
    hub_addr_d  = hub_addr_q;
    hub_mps_d   = hub_mps_q;
    hub_ival_d  = hub_ival_q;
    fail_now  = 1'b0;
    done      = 1'b0;
    msc_match = 1'b0;
    hub_match = 1'b0;
    ep_mps    = 16'd0;

    if (!failed_q) begin
      if (idx_q == 8'd0) begin
        len_d    = d;
        fail_now = (d < MIN_DESC_LEN) || (first_q && (d < MIN_CONFIG_LEN));
      end else if (idx_q == 8'd1) begin
        type_d   = d;
        fail_now = first_q && (d != DESC_CONFIG);
      end

      if (fail_now) begin
        failed_d = 1'b1;
      end else begin
        for (int k = 0; k < NUM_FIELDS; k++) begin
          if (idx_q == 8'(k + 2)) begin
            field_d[k] = d;
          end
        end
        if (first_q && (idx_q == 8'd5)) begin
          config_d = d;
        end

        done = ({1'b0, idx_q} + 9'd1) == {1'b0, len_d};
        if (done) begin
          idx_d   = 8'd0;
          first_d = 1'b0;
          // descriptor complete: act on its type
          if (type_d == DESC_INTERFACE) begin
            if (len_d < MIN_ITF_LEN) begin
              failed_d = 1'b1;
            end else if (field_d[1] != 8'd0) begin
              in_msc_d = 1'b0;
              in_hub_d = 1'b0;
            end else begin
              msc_match = (field_d[3] == CLASS_STORAGE) && (field_d[4] == SUBCLASS_SCSI)
                          && (field_d[5] == PROTO_BULK_ONLY) && !found_msc_q;
              hub_match = (field_d[3] == CLASS_HUB) && !found_hub_q;
              in_msc_d  = msc_match;
              in_hub_d  = hub_match;
              if (msc_match) begin
                found_msc_d = 1'b1;
                msc_itf_d   = field_d[0];
              end
              if (hub_match) begin
                found_hub_d = 1'b1;
              end
            end
          end else if (type_d == DESC_ENDPOINT) begin
            if (len_d < MIN_EP_LEN) begin
              failed_d = 1'b1;
            end else begin
              ep_mps = {field_d[3], field_d[2]};
              if (in_msc_q && (field_d[1][1:0] == XFER_BULK)) begin
                if (field_d[0][EP_DIR_BIT]) begin
                  bin_addr_d = field_d[0];
                  bin_mps_d  = ep_mps;
                end else begin
                  bout_addr_d = field_d[0];
                  bout_mps_d  = ep_mps;
                end
              end
              if (in_hub_q && (field_d[1][1:0] == XFER_INT) && field_d[0][EP_DIR_BIT]) begin
                hub_addr_d = field_d[0];
                hub_mps_d  = ep_mps;
                hub_ival_d = field_d[4];
              end
            end
          end
        end else if (item_i.last) begin
          failed_d = 1'b1;
        end else begin
          idx_d = idx_q + 8'd1;
        end
      end
    end
  end

  // result built from the state as it stands after this byte
  always_comb begin
    result_o.ok = !failed_d && (found_msc_d || found_hub_d)
                  && !(found_msc_d && ((bin_addr_d == 8'd0) || (bout_addr_d == 8'd0)))
                  && !(found_hub_d && (hub_addr_d == 8'd0));
    result_o.is_msc              = found_msc_d;
    result_o.is_hub              = found_hub_d;
    result_o.cfg_value           = config_d;
    result_o.msc_interface       = msc_itf_d;
    result_o.bulk_in_address     = bin_addr_d;
    result_o.bulk_in_max_packet  = bin_mps_d;
    result_o.bulk_out_address    = bout_addr_d;
    result_o.bulk_out_max_packet = bout_mps_d;
    result_o.hub_int_address     = hub_addr_d;
    result_o.hub_int_max_packet  = hub_mps_d;
    result_o.hub_poll_interval   = hub_ival_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 8'd0;
      len_q       <= 8'd0;
      type_q      <= 8'd0;
      field_q     <= '{default: 8'd0};
      first_q     <= 1'b1;
      failed_q    <= 1'b0;
      in_msc_q    <= 1'b0;
      in_hub_q    <= 1'b0;
      found_msc_q <= 1'b0;
      found_hub_q <= 1'b0;
      config_q    <= 8'd0;
      msc_itf_q   <= 8'd0;
      bin_addr_q  <= 8'd0;
      bin_mps_q   <= 16'd0;
      bout_addr_q <= 8'd0;
      bout_mps_q  <= 16'd0;
      hub_addr_q  <= 8'd0;
      hub_mps_q   <= 16'd0;
      hub_ival_q  <= 8'd0;
    end else if (en_i) begin
      if (item_i.last) begin
        // end of the set: start afresh
        idx_q       <= 8'd0;
        len_q       <= 8'd0;
        type_q      <= 8'd0;
        field_q     <= '{default: 8'd0};
        first_q     <= 1'b1;
        failed_q    <= 1'b0;
        in_msc_q    <= 1'b0;
        in_hub_q    <= 1'b0;
        found_msc_q <= 1'b0;
        found_hub_q <= 1'b0;
        config_q    <= 8'd0;
        msc_itf_q   <= 8'd0;
        bin_addr_q  <= 8'd0;
        bin_mps_q   <= 16'd0;
        bout_addr_q <= 8'd0;
        bout_mps_q  <= 16'd0;
        hub_addr_q  <= 8'd0;
        hub_mps_q   <= 16'd0;
        hub_ival_q  <= 8'd0;
      end else begin
        idx_q       <= idx_d;
        len_q       <= len_d;
        type_q      <= type_d;
        field_q     <= field_d;
        first_q     <= first_d;
        failed_q    <= failed_d;
        in_msc_q    <= in_msc_d;
        in_hub_q    <= in_hub_d;
        found_msc_q <= found_msc_d;
        found_hub_q <= found_hub_d;
        config_q    <= config_d;
        msc_itf_q   <= msc_itf_d;
        bin_addr_q  <= bin_addr_d;
        bin_mps_q   <= bin_mps_d;
        bout_addr_q <= bout_addr_d;
        bout_mps_q  <= bout_mps_d;
        hub_addr_q  <= hub_addr_d;
        hub_mps_q   <= hub_mps_d;
        hub_ival_q  <= hub_ival_d;
      end
    end
  end

  // failure only clears at the end of a set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (failed_q && !(en_i && item_i.last)) |=> failed_q)
    else $error("failure flag dropped inside a descriptor set");

  // byte position stays inside the current descriptor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!failed_q && (idx_q != 8'd0)) |-> (idx_q < len_q))
    else $error("byte index ran past descriptor length");

  // functions are only found once the header is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_msc_q || found_hub_q || in_msc_q || in_hub_q) |-> !first_q)
    else $error("interface recorded before configuration header completed");

endmodule

### rtl/usb_config_descriptor_parser.sv
// Parses a USB configuration descriptor set arriving one byte per transaction on the slave
// stream (tlast marks the final byte) and sends one result transaction per set on the master
// stream. Bytes are taken at one per clock cycle, with no gaps between sets; each byte passes
// through an input holding register and one parse step that updates the parser state. The
// result of a set is registered in the output register when its last byte leaves the holding
// register, and the input keeps flowing while a result waits, unless a second result is due
// before the first is taken. The parser resets itself after every last byte.
module usb_config_descriptor_parser
  import ucdp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,   // data_byte
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // ok, is_msc, is_hub, cfg_value, msc_interface, bulk_in_address, bulk_in_max_packet,
  // bulk_out_address, bulk_out_max_packet, hub_int_address, hub_int_max_packet,
  // hub_poll_interval, zero fill
  output logic [OUT_BYTES*8-1:0] m_axis_tdata_o
);

  logic     item_valid;
  in_item_t item;
  logic     advance;
  result_t  result;
  result_t  res_q;
  logic     out_valid_q, out_valid_d;

  // a last byte may only move on when the result register is free
  assign advance = item_valid && (!item.last || !out_valid_q || m_axis_tready_i);

  ucdp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_data_i     (s_axis_tdata_i),
    .s_last_i     (s_axis_tlast_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ucdp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (item),
    .result_o (result)
  );

  assign out_valid_d = (out_valid_q && !m_axis_tready_i) || (advance && item.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item.last) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD{1'b0}},
                            res_q.hub_poll_interval,
                            res_q.hub_int_max_packet,
                            res_q.hub_int_address,
                            res_q.bulk_out_max_packet,
                            res_q.bulk_out_address,
                            res_q.bulk_in_max_packet,
                            res_q.bulk_in_address,
                            res_q.msc_interface,
                            res_q.cfg_value,
                            res_q.is_hub,
                            res_q.is_msc,
                            res_q.ok};

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !(advance && item.last))
    else $error("pending result overwritten");

  // nothing is processed unless a byte is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> item_valid)
    else $error("parse step without a held byte");

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(m_axis_tdata_o)))
    else $error("result changed while stalled");

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import ucdp_pkg::*;
();

  localparam int unsigned TOTAL_BYTES = 1400;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;
  } desc_byte_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_valid = 1'b0;
  logic [7:0]             s_data = '0;
  logic                   s_last = 1'b0;
  logic                   s_ready;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_BYTES*8-1:0] m_data;

  desc_byte_t  byte_q[$];
  result_t     summary_q[$];
  logic [7:0]  set_bytes[$];
  logic [7:0]  desc_fields[NUM_FIELDS];
  int          mismatches = 0;
  int          cycles = 0;
  int          bytes_queued = 0;
  int          set_count = 0;
  wire         quiet = (cycles >= 2000) && (cycles < 3500);

  // parser mirror
  logic [7:0]  pos, dlen, dtype;
  logic [7:0]  fld[NUM_FIELDS];
  logic        at_header, broken, msc_open, hub_open, msc_seen, hub_seen;
  logic [7:0]  cfg_num, msc_itf;
  logic [23:0] bin_reg, bout_reg;
  logic [31:0] hub_reg;

  usb_config_descriptor_parser u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic clear_parser();
    pos = '0;
    dlen = '0;
    dtype = '0;
    for (int i = 0; i < NUM_FIELDS; i++) fld[i] = '0;
    at_header = 1'b1;
    broken = 1'b0;
    msc_open = 1'b0;
    hub_open = 1'b0;
    msc_seen = 1'b0;
    hub_seen = 1'b0;
    cfg_num = '0;
    msc_itf = '0;
    bin_reg = '0;
    bout_reg = '0;
    hub_reg = '0;
  endtask

  task automatic parse_byte(input logic [7:0] d, input logic lst, output bit emit,
                            output result_t r);
    logic [15:0] mps;
    r = '0;
    if (!broken) begin
      if (pos == 8'd0) begin
        if (d < MIN_DESC_LEN || (at_header && d < MIN_CONFIG_LEN)) broken = 1'b1;
        dlen = d;
      end else if (pos == 8'd1) begin
        dtype = d;
        if (at_header && d != DESC_CONFIG) broken = 1'b1;
      end
      if (!broken) begin
        if (pos >= 8'd2 && pos <= 8'd7) fld[pos - 8'd2] = d;
        if (at_header && pos == 8'd5) cfg_num = d;
        if ({1'b0, pos} + 9'd1 == {1'b0, dlen}) begin
          // descriptor complete
          mps = {fld[3], fld[2]};
          if (dtype == DESC_INTERFACE) begin
            if (dlen < MIN_ITF_LEN) begin
              broken = 1'b1;
            end else if (fld[1] != 8'd0) begin
              msc_open = 1'b0;
              hub_open = 1'b0;
            end else begin
              msc_open = fld[3] == CLASS_STORAGE && fld[4] == SUBCLASS_SCSI &&
                         fld[5] == PROTO_BULK_ONLY && !msc_seen;
              hub_open = fld[3] == CLASS_HUB && !hub_seen;
              if (msc_open) begin
                msc_seen = 1'b1;
                msc_itf = fld[0];
              end
              if (hub_open) hub_seen = 1'b1;
            end
          end else if (dtype == DESC_ENDPOINT) begin
            if (dlen < MIN_EP_LEN) begin
              broken = 1'b1;
            end else begin
              if (msc_open && fld[1][1:0] == XFER_BULK) begin
                if (fld[0][EP_DIR_BIT]) bin_reg = {mps, fld[0]};
                else bout_reg = {mps, fld[0]};
              end
              if (hub_open && fld[1][1:0] == XFER_INT && fld[0][EP_DIR_BIT])
                hub_reg = {fld[4], mps, fld[0]};
            end
          end
          pos = 8'd0;
          at_header = 1'b0;
        end else if (lst) begin
          broken = 1'b1;
        end else begin
          pos = pos + 8'd1;
        end
      end
    end
    emit = lst;
    if (lst) begin
      r.ok = !broken && (msc_seen || hub_seen);
      if (msc_seen && (bin_reg[7:0] == 8'd0 || bout_reg[7:0] == 8'd0)) r.ok = 1'b0;
      if (hub_seen && hub_reg[7:0] == 8'd0) r.ok = 1'b0;
      r.is_msc = msc_seen;
      r.is_hub = hub_seen;
      r.cfg_value = cfg_num;
      r.msc_interface = msc_itf;
      r.bulk_in_address = bin_reg[7:0];
      r.bulk_in_max_packet = bin_reg[23:8];
      r.bulk_out_address = bout_reg[7:0];
      r.bulk_out_max_packet = bout_reg[23:8];
      r.hub_int_address = hub_reg[7:0];
      r.hub_int_max_packet = hub_reg[23:8];
      r.hub_poll_interval = hub_reg[31:24];
      clear_parser();
    end
  endtask

  task automatic flush_set(input bit drain);
    for (int i = 0; i < set_bytes.size(); i++)
      byte_q.push_back('{set_bytes[i], i == set_bytes.size() - 1, drain && i == 0});
    bytes_queued += set_bytes.size();
    set_bytes.delete();
  endtask

  task automatic fresh_fields();
    for (int i = 0; i < NUM_FIELDS; i++) desc_fields[i] = 8'($urandom_range(255));
  endtask

  task automatic put_desc(input logic [7:0] len, input logic [7:0] kind);
    set_bytes.push_back(len);
    set_bytes.push_back(kind);
    for (int i = 2; i < len; i++)
      set_bytes.push_back(i - 2 < NUM_FIELDS ? desc_fields[i - 2] : 8'($urandom_range(255)));
  endtask

  // length around a nominal value: mostly exact, sometimes longer or short
  function automatic logic [7:0] pick_len(input int nominal);
    int roll;
    roll = $urandom_range(99);
    if (roll < 88) return 8'(nominal);
    if (roll < 94) return 8'($urandom_range(nominal + 5, nominal));
    return 8'($urandom_range(nominal - 1, 2));
  endfunction

  task automatic add_random_set(input bit drain);
    int n_desc, kind;
    logic [7:0] len, attr;
    // configuration header
    fresh_fields();
    kind = $urandom_range(99);
    if (kind < 5) len = 8'($urandom_range(8, 0));
    else if (kind < 85) len = MIN_CONFIG_LEN;
    else len = 8'($urandom_range(16, 10));
    put_desc(len, $urandom_range(99) < 5 ? 8'($urandom_range(255)) : DESC_CONFIG);
    n_desc = $urandom_range(6);
    for (int k = 0; k < n_desc; k++) begin
      fresh_fields();
      kind = $urandom_range(99);
      if (kind < 25) begin
        desc_fields[1] = $urandom_range(99) < 80 ? 8'd0 : 8'($urandom_range(255));
        desc_fields[3] = CLASS_STORAGE;
        desc_fields[4] = SUBCLASS_SCSI;
        desc_fields[5] = PROTO_BULK_ONLY;
        if ($urandom_range(99) < 10)
          desc_fields[3 + $urandom_range(2)] = 8'($urandom_range(255));
        put_desc(pick_len(9), DESC_INTERFACE);
      end else if (kind < 40) begin
        desc_fields[1] = $urandom_range(99) < 80 ? 8'd0 : 8'($urandom_range(255));
        desc_fields[3] = CLASS_HUB;
        put_desc(pick_len(9), DESC_INTERFACE);
      end else if (kind < 50) begin
        if ($urandom_range(1)) desc_fields[1] = 8'd0;
        put_desc(pick_len(9), DESC_INTERFACE);
      end else if (kind < 85) begin
        if ($urandom_range(99) < 15) desc_fields[0][6:0] = '0;
        attr = desc_fields[1];
        if ($urandom_range(99) < 70) attr[1:0] = $urandom_range(1) ? XFER_BULK : XFER_INT;
        desc_fields[1] = attr;
        put_desc(pick_len(7), DESC_ENDPOINT);
      end else begin
        kind = $urandom_range(99);
        if (kind < 3) len = 8'($urandom_range(1, 0));
        else if (kind < 5) len = 8'($urandom_range(255, 200));
        else len = 8'($urandom_range(12, 2));
        put_desc(len, 8'($urandom_range(255)));
      end
    end
    // cut the set short now and then
    if ($urandom_range(99) < 8 && set_bytes.size() > 1)
      set_bytes = set_bytes[0:$urandom_range(set_bytes.size() - 1, 1) - 1];
    flush_set(drain);
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("usb_config_descriptor_parser: mismatch");
      $finish;
    end
  end

  // byte sender, predicts each accepted transaction
  always @(posedge clk_i) begin : drive
    desc_byte_t nxt;
    bit         emit;
    result_t    want;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        parse_byte(s_data, s_last, emit, want);
        if (emit) summary_q.push_back(want);
      end
      if (!s_valid || s_ready) begin
        if (byte_q.size() != 0 && (quiet || $urandom_range(99) >= 21) &&
            !(byte_q[0].drain && summary_q.size() != 0)) begin
          nxt = byte_q.pop_front();
          s_valid <= 1'b1;
          s_data <= nxt.data;
          s_last <= nxt.last;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) m_ready <= 1'b0;
    else m_ready <= quiet || $urandom_range(99) >= 21;
  end

  // result checker, fields from the lowest bit up
  always @(posedge clk_i) begin : watch
    result_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (summary_q.size() == 0) begin
        report("result with nothing expected", m_data[15:0], 16'h0);
      end else begin
        want = summary_q.pop_front();
        if (m_data[0] !== want.ok) report("ok", 16'(m_data[0]), 16'(want.ok));
        if (m_data[1] !== want.is_msc)
          report("is_msc", 16'(m_data[1]), 16'(want.is_msc));
        if (m_data[2] !== want.is_hub)
          report("is_hub", 16'(m_data[2]), 16'(want.is_hub));
        if (m_data[10:3] !== want.cfg_value)
          report("cfg_value", 16'(m_data[10:3]), 16'(want.cfg_value));
        if (m_data[18:11] !== want.msc_interface)
          report("msc_interface", 16'(m_data[18:11]), 16'(want.msc_interface));
        if (m_data[26:19] !== want.bulk_in_address)
          report("bulk_in_address", 16'(m_data[26:19]), 16'(want.bulk_in_address));
        if (m_data[42:27] !== want.bulk_in_max_packet)
          report("bulk_in_max_packet", m_data[42:27], want.bulk_in_max_packet);
        if (m_data[50:43] !== want.bulk_out_address)
          report("bulk_out_address", 16'(m_data[50:43]), 16'(want.bulk_out_address));
        if (m_data[66:51] !== want.bulk_out_max_packet)
          report("bulk_out_max_packet", m_data[66:51], want.bulk_out_max_packet);
        if (m_data[74:67] !== want.hub_int_address)
          report("hub_int_address", 16'(m_data[74:67]), 16'(want.hub_int_address));
        if (m_data[90:75] !== want.hub_int_max_packet)
          report("hub_int_max_packet", m_data[90:75], want.hub_int_max_packet);
        if (m_data[98:91] !== want.hub_poll_interval)
          report("hub_poll_interval", 16'(m_data[98:91]), 16'(want.hub_poll_interval));
        if (m_data[OUT_BYTES*8-1:OUT_BITS] !== '0)
          report("zero fill", 16'(m_data[OUT_BYTES*8-1:OUT_BITS]), 16'h0);
      end
    end
  end

  initial begin
    clear_parser();
    // header length under 2
    set_bytes = {8'h00};
    flush_set(1'b0);
    // header length under 9
    set_bytes = {8'h08, DESC_CONFIG};
    flush_set(1'b0);
    // header of wrong type
    set_bytes = {8'h09, 8'h03};
    flush_set(1'b0);
    // set ends inside the header
    set_bytes = {8'hFF};
    flush_set(1'b0);
    // good header then a descriptor that is too short
    set_bytes = {8'h09, DESC_CONFIG, 8'hFF, 8'h00, 8'h01, 8'hA5, 8'h00, 8'h80, 8'hFA,
                 8'h01, DESC_INTERFACE};
    flush_set(1'b0);
    while (bytes_queued < TOTAL_BYTES) begin
      add_random_set(set_count == 20 || set_count == 40);
      set_count++;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (byte_q.size() != 0 || s_valid) @(posedge clk_i);
    while (summary_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && summary_q.size() == 0) begin
      $display("usb_config_descriptor_parser: match");
    end else begin
      $display("usb_config_descriptor_parser: mismatch");
    end
    $finish;
  end

endmodule
